FILE: hdl/mi_pkg.sv
// mi_pkg: shared constants and controller/datapath interface types for the
// modular inverse block. No dependencies.
package mi_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FIELD_W        = 31;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture a new item
    logic init_euc;  // start a division for one Euclid step
    logic init_red;  // start the final reduction of the coefficient
    logic div_step;  // one restoring division bit
    logic euc_upd;   // shift the remainder/coefficient pairs
    logic out_load;  // fill the output register
  } mi_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic r_cur_zero;
    logic mod_zero;
    logic div_last;
  } mi_stat_t;

endpackage

FILE: hdl/mi_dpath.sv
// mi_dpath: remainder/coefficient registers, shared radix-2 divider with
// quotient-times-coefficient accumulator, and the output payload register.
// Depends on mi_pkg.
module mi_dpath import mi_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mi_cmd_t            cmd,
  output mi_stat_t           stat,
  input  logic [FIELD_W-1:0] in_operand_value,
  input  logic [FIELD_W-1:0] in_modulus,
  output logic [FIELD_W-1:0] out_inverse,
  output logic [FIELD_W-1:0] out_common_divisor
);

  localparam int OPW = (DATA_WIDTH - 1 > FIELD_W) ? FIELD_W : DATA_WIDTH - 1;
  localparam int CW  = OPW + 3;            // signed coefficient width
  localparam int CNW = $clog2(CW);

  logic [OPW-1:0]        r_prev_r, r_prev_nxt, r_cur_r, r_cur_nxt, mod_r, mod_nxt;
  logic signed [CW-1:0]  c_prev_r, c_prev_nxt, c_cur_r, c_cur_nxt;
  logic signed [CW-1:0]  acc_r, acc_nxt;
  logic [CW-1:0]         num_r, num_nxt;
  logic [OPW-1:0]        rem_r, rem_nxt;
  logic [CNW-1:0]        cnt_r, cnt_nxt;
  logic                  red_r, red_nxt;
  logic [OPW-1:0]        inv_r, inv_nxt, gcd_r, gcd_nxt;

  logic [OPW-1:0]        divisor;
  logic [OPW:0]          rem_shift;
  logic [OPW+1:0]        diff;
  logic                  ge;
  logic [CW-1:0]         c_prev_mag;

  assign divisor    = red_r ? mod_r : r_cur_r;
  assign rem_shift  = {rem_r, num_r[CW-1]};
  assign diff       = {1'b0, rem_shift} - {2'b00, divisor};
  assign ge         = ~diff[OPW+1];
  assign c_prev_mag = c_prev_r[CW-1] ? CW'(-c_prev_r) : CW'(c_prev_r);

  assign stat.r_cur_zero = (r_cur_r == '0);
  assign stat.mod_zero   = (mod_r == '0);
  assign stat.div_last   = (cnt_r == '0);

  always_comb begin
    r_prev_nxt = r_prev_r;
    r_cur_nxt  = r_cur_r;
    mod_nxt    = mod_r;
    c_prev_nxt = c_prev_r;
    c_cur_nxt  = c_cur_r;
    acc_nxt    = acc_r;
    num_nxt    = num_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    red_nxt    = red_r;
    inv_nxt    = inv_r;
    gcd_nxt    = gcd_r;
    if (cmd.load) begin
      r_prev_nxt = in_modulus[OPW-1:0];
      mod_nxt    = in_modulus[OPW-1:0];
      r_cur_nxt  = in_operand_value[OPW-1:0];
      c_prev_nxt = '0;
      c_cur_nxt  = CW'(1);
    end
    if (cmd.init_euc || cmd.init_red) begin
      num_nxt = cmd.init_red ? c_prev_mag : CW'(r_prev_r);
      red_nxt = cmd.init_red;
      rem_nxt = '0;
      acc_nxt = '0;
      cnt_nxt = CNW'(CW - 1);
    end
    if (cmd.div_step) begin
      // quotient bits come MSB first, so q*c_cur builds by shift-and-add
      rem_nxt = ge ? diff[OPW-1:0] : rem_shift[OPW-1:0];
      num_nxt = {num_r[CW-2:0], 1'b0};
      acc_nxt = CW'(acc_r <<< 1) + (ge ? c_cur_r : CW'(0));
      cnt_nxt = cnt_r - CNW'(1);
    end
    if (cmd.euc_upd) begin
      r_prev_nxt = r_cur_r;
      r_cur_nxt  = rem_r;
      c_prev_nxt = c_cur_r;
      c_cur_nxt  = c_prev_r - acc_r;
    end
    if (cmd.out_load) begin
      gcd_nxt = r_prev_r;
      if (mod_r == '0) begin
        inv_nxt = '0;
      end else if (c_prev_r[CW-1] && rem_r != '0) begin
        inv_nxt = mod_r - rem_r;
      end else begin
        inv_nxt = rem_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    r_prev_r <= r_prev_nxt;
    r_cur_r  <= r_cur_nxt;
    mod_r    <= mod_nxt;
    c_prev_r <= c_prev_nxt;
    c_cur_r  <= c_cur_nxt;
    acc_r    <= acc_nxt;
    num_r    <= num_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    inv_r    <= inv_nxt;
    gcd_r    <= gcd_nxt;
    if (!rst_n) begin
      red_r <= 1'b0;
    end else begin
      red_r <= red_nxt;
    end
  end

  assign out_inverse        = FIELD_W'(inv_r);
  assign out_common_divisor = FIELD_W'(gcd_r);

endmodule

FILE: hdl/mi_ctrl.sv
// mi_ctrl: sequencer for the Euclid steps, the final reduction and the
// output handshake. Depends on mi_pkg.
module mi_ctrl import mi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  mi_stat_t stat,
  output mi_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_EDIV  = 3'd2;
  localparam logic [2:0] ST_EUPD  = 3'd3;
  localparam logic [2:0] ST_RDIV  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (!stat.r_cur_zero) begin
          cmd.init_euc = 1'b1;
          state_nxt    = ST_EDIV;
        end else if (stat.mod_zero) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.init_red = 1'b1;
          state_nxt    = ST_RDIV;
        end
      end
      ST_EDIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = ST_EUPD;
      end
      ST_EUPD: begin
        cmd.euc_upd = 1'b1;
        state_nxt   = ST_CHECK;
      end
      ST_RDIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hdl/modular_inverse.sv
// modular_inverse: top level, joins controller and datapath.
// Depends on mi_pkg, mi_ctrl, mi_dpath.
//
// Modular inverse by the iterative extended Euclidean algorithm. Each item
// (operand value, modulus) yields one result: the Bezout coefficient of the
// value reduced into 0..modulus-1, and the gcd; the inverse is meaningful
// only when the gcd is 1. One item is in work at a time. Every Euclid step
// runs one radix-2 restoring division of CW = W+3 bits on a shared divider,
// with W = min(DATA_WIDTH-1, 31) operand bits, and then shifts the
// remainder/coefficient pairs; the last coefficient is reduced on the same
// divider. A zero value skips the Euclid steps. A new item is taken while the
// previous result still waits in the output register.
module modular_inverse import mi_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FIELD_W-1:0] in_operand_value,
  input  logic [FIELD_W-1:0] in_modulus,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FIELD_W-1:0] out_inverse,
  output logic [FIELD_W-1:0] out_common_divisor
);

  mi_cmd_t  cmd;
  mi_stat_t stat;

  mi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mi_dpath #(.DATA_WIDTH(DATA_WIDTH)) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_operand_value   (in_operand_value),
    .in_modulus         (in_modulus),
    .out_inverse        (out_inverse),
    .out_common_divisor (out_common_divisor)
  );

endmodule

FILE: hdl/mi_checker.sv
// mi_checker: port-level assertions for modular_inverse, bound to the top.
// Depends on mi_pkg.
module mi_checker import mi_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [FIELD_W-1:0] in_operand_value,
  input logic [FIELD_W-1:0] in_modulus,
  input logic               out_valid,
  input logic               out_ready,
  input logic [FIELD_W-1:0] out_inverse,
  input logic [FIELD_W-1:0] out_common_divisor
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_inverse)
      && $stable(out_common_divisor))
    else $error("result changed while stalled");

  // one item in work at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // gcd zero only for zero value with zero modulus, where inverse is zero
  a_gcd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_common_divisor == '0 |-> out_inverse == '0)
    else $error("nonzero inverse with zero gcd");

endmodule

bind modular_inverse mi_checker u_mi_checker (.*);
